>>> design/uppd_pkg.sv
`default_nettype none
package uppd_pkg;

   localparam logic [7:0] CHAR_PERCENT   = 8'h25;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;

   // Number of results an encoded slash or backslash expands into.
   localparam int unsigned TRIPLE_LEN = 3;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // One unit of work for the back end: either a single result or a
   // three-result pass-through of an encoded separator.
   typedef struct packed {
      logic       triple;
      logic [7:0] hex1;
      logic [7:0] data;
      logic       bad;
      logic       path_end;
   } cmd_type;

   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = c - 8'h30;
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         v = c - 8'h57;
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         v = c - 8'h37;
      end
      hex_val = v[3:0];
   endfunction

endpackage
`default_nettype wire

>>> design/uppd_front.sv
`default_nettype none
module uppd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire logic             path_last,
   output logic                  push,
   output uppd_pkg::cmd_type     push_cmd
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PCT,
      PH_HEX1,
      PH_DROP
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] first_hex_ff, first_hex_in;
   logic [7:0] decoded;

   assign decoded = {uppd_pkg::hex_val(first_hex_ff), uppd_pkg::hex_val(in_byte)};

   always_comb begin
      phase_in          = phase_ff;
      first_hex_in      = first_hex_ff;
      push              = 1'b0;
      push_cmd.triple   = 1'b0;
      push_cmd.hex1     = first_hex_ff;
      push_cmd.data     = 8'h00;
      push_cmd.bad      = 1'b1;
      push_cmd.path_end = 1'b1;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (in_byte != uppd_pkg::CHAR_PERCENT) begin
                  push              = 1'b1;
                  push_cmd.data     = in_byte;
                  push_cmd.bad      = 1'b0;
                  push_cmd.path_end = path_last;
               end else if (path_last) begin
                  push = 1'b1;
               end else begin
                  phase_in = PH_PCT;
               end
            end
            PH_PCT: begin
               if (!uppd_pkg::hex_ok(in_byte) || path_last) begin
                  push     = 1'b1;
                  phase_in = path_last ? PH_IDLE : PH_DROP;
               end else begin
                  first_hex_in = in_byte;
                  phase_in     = PH_HEX1;
               end
            end
            PH_HEX1: begin
               push = 1'b1;
               if (!uppd_pkg::hex_ok(in_byte)) begin
                  phase_in = path_last ? PH_IDLE : PH_DROP;
               end else begin
                  phase_in          = PH_IDLE;
                  push_cmd.bad      = 1'b0;
                  push_cmd.path_end = path_last;
                  // Encoded separators are kept as their original three characters.
                  if ((decoded == uppd_pkg::CHAR_SLASH) ||
                      (decoded == uppd_pkg::CHAR_BACKSLASH)) begin
                     push_cmd.triple = 1'b1;
                     push_cmd.data   = in_byte;
                  end else begin
                     push_cmd.data = decoded;
                  end
               end
            end
            default: begin
               if (path_last) begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         first_hex_ff <= 8'h00;
      end else begin
         phase_ff     <= phase_in;
         first_hex_ff <= first_hex_in;
      end
   end

endmodule
`default_nettype wire

>>> design/uppd_queue.sv
`default_nettype none
module uppd_queue #(
   parameter int unsigned DEPTH = uppd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire uppd_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output uppd_pkg::cmd_type      head_cmd
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   uppd_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> design/uppd_back.sv
`default_nettype none
module uppd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire uppd_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [7:0]             out_byte,
   output logic                   bad_encoding,
   output logic                   path_end,
   output logic                   run_last
);

   localparam int unsigned IDX_W = $clog2(uppd_pkg::TRIPLE_LEN);

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       byte_ff, byte_in;
   logic             bad_ff, bad_in;
   logic             end_ff, end_in;
   logic             last_ff, last_in;
   logic             load;

   // The output register takes a new beat whenever it is empty or being drained.
   assign load = cmd_valid && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      bad_in   = bad_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      cmd_pop  = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         bad_in   = cmd.bad;
         if (!cmd.triple) begin
            byte_in = cmd.data;
            end_in  = cmd.path_end;
            last_in = 1'b1;
            cmd_pop = 1'b1;
         end else if (idx_ff == IDX_W'(uppd_pkg::TRIPLE_LEN - 1)) begin
            byte_in = cmd.data;
            end_in  = cmd.path_end;
            last_in = 1'b1;
            cmd_pop = 1'b1;
            idx_in  = '0;
         end else begin
            byte_in = (idx_ff == '0) ? uppd_pkg::CHAR_PERCENT : cmd.hex1;
            end_in  = 1'b0;
            last_in = 1'b0;
            idx_in  = idx_ff + 1'b1;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bad_ff  <= bad_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign bad_encoding = bad_ff;
   assign path_end     = end_ff;
   assign run_last     = last_ff;

endmodule
`default_nettype wire

>>> design/url_path_percent_decoder_unit.sv
// URL path percent decoder.
// Input stream req_*: one path byte per beat in req_tdata, req_tlast on the
// path's final byte. Output stream rsp_*: one result byte per beat in
// rsp_tdata, rsp_tlast when the beat closes the path, rsp_tuser[0] flags a
// malformed escape (data zero) and rsp_tuser[1] marks the last beat caused
// by one input byte.
// A byte accepted on req_* is written into the command queue and from there
// into the output register before its first result shows on rsp_*.
// The front end classifies one byte per cycle while req_tready is high; the
// back end emits one beat per cycle while rsp_tready is high, so throughput is
// one byte per cycle, except that an encoded slash or backslash yields three beats.
// The command queue of QUEUE_DEPTH entries absorbs this; req_tready falls
// only while it is full.
// A stalled receiver leaves the output register holding its beat; the
// queue keeps filling until full, then req_tready drops.
// Reset clears the queue, the output register and the escape state; the
// block is ready for input as soon as reset is released.
`default_nettype none
module url_path_percent_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = uppd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [0] bad_encoding, [1] run_last
   output logic            rsp_tlast
);

   logic              accept;
   logic              push;
   uppd_pkg::cmd_type push_cmd;
   logic              q_full;
   logic              q_not_empty;
   uppd_pkg::cmd_type head_cmd;
   logic              pop;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   uppd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_tdata),
      .path_last (req_tlast),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   uppd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   uppd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (q_not_empty),
      .cmd          (head_cmd),
      .cmd_pop      (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .bad_encoding (rsp_tuser[0]),
      .path_end     (rsp_tlast),
      .run_last     (rsp_tuser[1])
   );

   // An error beat is always a lone, path-closing beat carrying zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tuser[1] && (rsp_tdata == 8'h00))
      else $error("error beat malformed");

   // A path never closes in the middle of one input byte's results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("path end before run end");

   // The queue is never pushed while full, so no command is lost.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("push into full queue");

endmodule
`default_nettype wire

>>> tb/tb_url_path_percent_decoder_unit.sv
`timescale 1ns / 1ps

module tb_url_path_percent_decoder_unit;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned ITEM_COUNT   = 450;
   localparam int unsigned DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       path_last;
   } path_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       bad_encoding;
      logic       path_end;
      logic       run_last;
   } decoded_beat_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PERCENT,
      PH_FIRST_DIGIT,
      PH_DROP
   } decode_phase_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [1:0] rsp_tuser;           // [0] bad_encoding, [1] run_last
   logic       rsp_tlast;

   path_beat_type    path_bytes[$];
   decoded_beat_type decoded_bytes[$];
   decode_phase_type dec_phase = PH_IDLE;
   logic [7:0]       held_digit = 8'h00;

   int unsigned bytes_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned failures        = 0;
   int unsigned cycle_count     = 0;
   int unsigned send_gap        = 0;
   int unsigned stall_left      = 0;
   bit          hold_active     = 1'b0;
   bit          hold_done       = 1'b0;
   int unsigned ready_roll;
   path_beat_type    next_beat;
   decoded_beat_type want;

   url_path_percent_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c) - int'("0");
      end
      if (c >= "a" && c <= "f") begin
         return int'(c) - int'("a") + 10;
      end
      if (c >= "A" && c <= "F") begin
         return int'(c) - int'("A") + 10;
      end
      return -1;
   endfunction

   task automatic expect_beat(input logic [7:0] b, input logic bad, input logic fin,
                              input logic run_end);
      decoded_beat_type beat;
      beat.out_byte     = b;
      beat.bad_encoding = bad;
      beat.path_end     = fin;
      beat.run_last     = run_end;
      decoded_bytes.insert(decoded_bytes.size(), beat);
   endtask

   task automatic reject_path(input logic fin);
      expect_beat(8'h00, 1'b1, 1'b1, 1'b1);
      dec_phase = fin ? PH_IDLE : PH_DROP;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic fin);
      int         d0;
      int         d1;
      logic [7:0] c;
      d0 = digit_value(held_digit);
      d1 = digit_value(b);
      case (dec_phase)
         PH_IDLE: begin
            if (b != uppd_pkg::CHAR_PERCENT) begin
               expect_beat(b, 1'b0, fin, 1'b1);
            end else if (fin) begin
               reject_path(fin);
            end else begin
               dec_phase = PH_PERCENT;
            end
         end
         PH_PERCENT: begin
            if (d1 < 0 || fin) begin
               reject_path(fin);
            end else begin
               held_digit = b;
               dec_phase  = PH_FIRST_DIGIT;
            end
         end
         PH_FIRST_DIGIT: begin
            if (d0 < 0 || d1 < 0) begin
               reject_path(fin);
            end else begin
               dec_phase = PH_IDLE;
               c = 8'(d0 * 16 + d1);
               // Encoded separators are passed on undecoded, as three beats.
               if (c == uppd_pkg::CHAR_SLASH || c == uppd_pkg::CHAR_BACKSLASH) begin
                  expect_beat(uppd_pkg::CHAR_PERCENT, 1'b0, 1'b0, 1'b0);
                  expect_beat(held_digit, 1'b0, 1'b0, 1'b0);
                  expect_beat(b, 1'b0, fin, 1'b1);
               end else begin
                  expect_beat(c, 1'b0, fin, 1'b1);
               end
            end
         end
         default: begin
            if (fin) begin
               dec_phase = PH_IDLE;
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] hex_char(input int unsigned v, input bit upper);
      if (v < 10) begin
         return 8'(int'("0") + v);
      end
      return 8'((upper ? int'("A") : int'("a")) + v - 10);
   endfunction

   task automatic add_path_byte(input logic [7:0] b, input logic fin);
      path_beat_type beat;
      beat.in_byte   = b;
      beat.path_last = fin;
      path_bytes.insert(path_bytes.size(), beat);
   endtask

   task automatic queue_path(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_path_byte(s[i], i == s.len() - 1);
      end
   endtask

   task automatic queue_random_path();
      logic [7:0]  chars[$];
      int unsigned tokens;
      int unsigned kind;
      int unsigned v;
      logic [7:0]  b;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4) begin
            b = 8'($urandom_range(0, 255));
            chars.insert(chars.size(), (b == uppd_pkg::CHAR_PERCENT) ? 8'h7e : b);
         end else if (kind <= 8) begin
            case (kind)
               7:       v = uppd_pkg::CHAR_SLASH;
               8:       v = uppd_pkg::CHAR_BACKSLASH;
               default: v = $urandom_range(0, 255);
            endcase
            chars.insert(chars.size(), uppd_pkg::CHAR_PERCENT);
            chars.insert(chars.size(), hex_char(v >> 4, 1'($urandom_range(0, 1))));
            chars.insert(chars.size(), hex_char(v & 15, 1'($urandom_range(0, 1))));
         end else begin
            // Broken escape: a stray byte for either digit, or a bare percent.
            chars.insert(chars.size(), uppd_pkg::CHAR_PERCENT);
            case ($urandom_range(0, 2))
               0: chars.insert(chars.size(), 8'($urandom_range(0, 255)));
               1: begin
                  chars.insert(chars.size(),
                               hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
                  chars.insert(chars.size(), 8'($urandom_range(0, 255)));
               end
               default: ;
            endcase
         end
      end
      foreach (chars[i]) begin
         add_path_byte(chars[i], i == chars.size() - 1);
      end
   endtask

   task automatic queue_noise();
      int unsigned n;
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         add_path_byte(8'($urandom_range(0, 255)),
                       (i == n - 1) || ($urandom_range(0, 3) == 0));
      end
   endtask

   initial begin
      add_path_byte(8'h00, 1'b0);
      add_path_byte(8'hff, 1'b1);
      queue_path("%4a%2f%5C");
      queue_path("%Fe");
      queue_path("%gx%");
      queue_path("%4z");
      queue_path("%");
      queue_path("%4");
      queue_path("%/");
      queue_path("ok");
      while (path_bytes.size() < ITEM_COUNT) begin
         if ($urandom_range(0, 9) < 8) begin
            queue_random_path();
         end else begin
            queue_noise();
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (path_bytes.size() != 0 || req_tvalid || decoded_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (failures == 0) begin
         $display("url_path_percent_decoder_unit test passed");
      end else begin
         $display("url_path_percent_decoder_unit test failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   function automatic int unsigned pick_send_gap();
      int unsigned r;
      if (hold_active || (bytes_accepted >= 150 && bytes_accepted < 230)) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = pick_send_gap();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (path_bytes.size() > 0) begin
               next_beat = path_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_beat.in_byte;
               req_tlast  <= next_beat.path_last;
               send_gap = pick_send_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input logic [7:0] expected_val,
                              input logic [7:0] actual_val);
      if (actual_val !== expected_val) begin
         $error("%s: expected %0h, actual %0h", name, expected_val, actual_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (decoded_bytes.size() == 0) begin
               $error("unexpected result beat: out_byte %0h", rsp_tdata);
               failures++;
            end else begin
               want = decoded_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_tdata);
               check_field("bad_encoding", 8'(want.bad_encoding), 8'(rsp_tuser[0]));
               check_field("path_end", 8'(want.path_end), 8'(rsp_tlast));
               check_field("run_last", 8'(want.run_last), 8'(rsp_tuser[1]));
            end
         end

         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            hold_active = 1'b0;
            ready_roll = $urandom_range(0, 99);
            if (!hold_done && results_checked >= 120) begin
               // One long back-pressure stretch so the command queue fills up.
               hold_done   = 1'b1;
               hold_active = 1'b1;
               stall_left  = 100;
               rsp_tready <= 1'b0;
            end else if (results_checked >= 300 && results_checked < 380) begin
               rsp_tready <= 1'b1;
            end else if (ready_roll < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("url_path_percent_decoder_unit test failed");
         $finish;
      end
   end

endmodule
